[src/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg
// Shared widths, reset values, reject codes and the cell link type of the
// sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DELAY_W      = 16;
    localparam int TAG_W        = 8;
    localparam int FREQ_W       = 32;
    localparam int RELOAD_W     = DELAY_W + FREQ_W;
    localparam int AFTER_W      = 5;
    localparam int CAUSE_W      = 2;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(19200000);

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_ZERO = 2'd1,
        CAUSE_FULL = 2'd2
    } t_cause;

    // Data one cell hands to the cell behind it.
    typedef struct packed {
        logic               occupied;
        logic               ge;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } t_link;

endpackage

[src/stq_if.sv]
// ----------------------------------------------------------------------------
// stq_if
// Valid/ready channels of the sorted timer queue: request in, result out.
// ----------------------------------------------------------------------------
interface stq_req_if;
    logic                         valid;
    logic                         ready;
    logic [stq_pkg::DELAY_W-1:0]  delay_seconds;
    logic [stq_pkg::TAG_W-1:0]    payload_tag;

    modport source (output valid, output delay_seconds, output payload_tag, input ready);
    modport sink   (input valid, input delay_seconds, input payload_tag, output ready);
endinterface

interface stq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [stq_pkg::CAUSE_W-1:0]  reject_cause;
    logic                         became_head;
    logic [stq_pkg::RELOAD_W-1:0] reload_value;
    logic [stq_pkg::AFTER_W-1:0]  entries_after;

    modport source (output valid, output accepted, output reject_cause, output became_head,
                    output reload_value, output entries_after, input ready);
    modport sink   (input valid, input accepted, input reject_cause, input became_head,
                    input reload_value, input entries_after, output ready);
endinterface

[src/stq_cell.sv]
// ----------------------------------------------------------------------------
// stq_cell
// One queue slot: holds a delay and a tag, compares the incoming delay
// against its own, and on insert either keeps, loads the new item or takes
// the entry of the cell in front of it.
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic                   i_clk,
    input  logic                   i_occupied,
    input  logic                   i_insert,
    input  logic [stq_pkg::DELAY_W-1:0] i_new_delay,
    input  logic [stq_pkg::TAG_W-1:0]   i_new_tag,
    input  stq_pkg::t_link         i_prev,
    output stq_pkg::t_link         o_link,
    output logic                   o_load
);
    import stq_pkg::*;

    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic               ge;
    logic               shift;

    // Compare: new item goes in front of this entry
    assign ge     = i_occupied && (i_new_delay <= r_delay);
    // Load where the first entry not below the new one sits, or at the tail
    assign o_load = i_insert && i_prev.occupied && !i_prev.ge && (ge || !i_occupied);
    assign shift  = i_insert && i_prev.ge;

    always_comb begin
        n_delay = r_delay;
        n_tag   = r_tag;
        priority if (shift) begin
            n_delay = i_prev.delay;
            n_tag   = i_prev.tag;
        end else if (o_load) begin
            n_delay = i_new_delay;
            n_tag   = i_new_tag;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge i_clk) begin
        r_delay <= n_delay;
        r_tag   <= n_tag;
    end

    // Hand own state to the next cell
    assign o_link.occupied = i_occupied;
    assign o_link.ge       = ge;
    assign o_link.delay    = r_delay;
    assign o_link.tag      = r_tag;

endmodule

[src/sorted_timer_queue_insert.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue_insert
// Bounded timer queue kept in rising delay order, insert side only.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle and delivers its result in the next cycle
// from an output register; a request is taken whenever the output register is
// empty or its result is being taken in the same cycle. Every cell of the row
// compares the new delay with its own while the request is taken, the
// row shifts the tail back by one slot, and an OR encode over the row's one-hot
// load flags gives the insert position. The reload value comes from one 16 x 32
// multiply that runs alongside. Requests with zero delay or arriving at a full
// queue are rejected and leave the queue unchanged. No clearing after reset.
// ----------------------------------------------------------------------------
module sorted_timer_queue_insert #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [stq_pkg::FREQ_W-1:0] i_cfg_wr_data,
    stq_req_if.sink                    i_req,
    stq_rsp_if.source                  o_rsp
);
    import stq_pkg::*;

    localparam int POS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > AFTER_W) ? CNT_W : AFTER_W;

    logic [FREQ_W-1:0] r_freq;
    logic [CNT_W-1:0]  r_count;

    logic              accept;
    logic              zero_delay;
    logic              full;
    logic              insert;

    t_link             link [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] load;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  after_cnt;
    logic [EXT_W-1:0]  after_ext;
    logic [RELOAD_W-1:0] product;

    logic                r_out_valid;
    logic                r_accepted;
    t_cause              r_cause;
    logic                r_head;
    logic [RELOAD_W-1:0] r_reload;
    logic [AFTER_W-1:0]  r_after;

    // Handshake and reject checks
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign zero_delay  = (i_req.delay_seconds == '0);
    assign full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign insert      = accept && !zero_delay && !full;

    // Head of the chain: always free to load, nothing to shift in
    assign link[0].occupied = 1'b1;
    assign link[0].ge       = 1'b0;
    assign link[0].delay    = '0;
    assign link[0].tag      = '0;

    // Row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        stq_cell u_cell (
            .i_clk       (i_clk),
            .i_occupied  (r_count > CNT_W'(g)),
            .i_insert    (insert),
            .i_new_delay (i_req.delay_seconds),
            .i_new_tag   (i_req.payload_tag),
            .i_prev      (link[g]),
            .o_link      (link[g+1]),
            .o_load      (load[g])
        );
    end

    // Encode the insert position from the one-hot load flags
    always_comb begin
        pos = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            pos = pos | (load[k] ? POS_W'(k) : POS_W'(0));
        end
    end

    // Entries behind the new one: old count minus position, 5-bit wrap
    assign after_cnt = r_count - CNT_W'(pos);
    assign after_ext = EXT_W'(after_cnt);
    assign product   = RELOAD_W'(i_req.delay_seconds) * RELOAD_W'(r_freq);

    // Frequency register and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= FREQ_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_freq <= i_cfg_wr_data;
            end
            if (insert) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture result fields of an accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_accepted <= insert;
            r_head     <= insert && load[0];
            r_reload   <= (insert && load[0]) ? product : '0;
            r_after    <= insert ? after_ext[AFTER_W-1:0] : '0;
            priority if (zero_delay) begin
                r_cause <= CAUSE_ZERO;
            end else if (full) begin
                r_cause <= CAUSE_FULL;
            end else begin
                r_cause <= CAUSE_NONE;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.accepted      = r_accepted;
    assign o_rsp.reject_cause  = r_cause;
    assign o_rsp.became_head   = r_head;
    assign o_rsp.reload_value  = r_reload;
    assign o_rsp.entries_after = r_after;

endmodule
